/* hdl/msq_pkg.sv */
// shared constants and types for the motion sensor event qualifier
// no dependencies; imported by msq_core, motion_sensor_event_qualifier and the testbench
`timescale 1ns / 1ps
`default_nettype none

package msq_pkg;

  localparam int TIME_WIDTH  = 48;
  localparam int COUNT_WIDTH = 32;
  localparam int MS_WIDTH    = 32;
  localparam int CMP_WIDTH   = (TIME_WIDTH > MS_WIDTH) ? TIME_WIDTH : MS_WIDTH;

  localparam int CFG_INDEX_WIDTH = 2;
  localparam int CFG_DATA_WIDTH  = 48;

  localparam logic [CFG_INDEX_WIDTH-1:0] REG_ACTIVE_POLARITY = 2'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_START_TIME      = 2'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_WARMUP_MS       = 2'd2;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_HOLDOFF_MS      = 2'd3;

  localparam int IN_DATA_WIDTH  = 56;
  localparam int OUT_DATA_WIDTH = 88;

  typedef struct packed {
    logic                  active_polarity;
    logic [TIME_WIDTH-1:0] start_time;
    logic [MS_WIDTH-1:0]   warmup_ms;
    logic [MS_WIDTH-1:0]   holdoff_ms;
  } msq_cfg_t;

  typedef struct packed {
    logic                   seen_first;
    logic                   warmed_up;
    logic                   prev_active;
    logic [COUNT_WIDTH-1:0] events_seen;
    logic [TIME_WIDTH-1:0]  last_fire_time;
  } msq_state_t;

endpackage

`default_nettype wire

/* hdl/msq_core.sv */
// next-state and result logic for one detector sample
// depends on msq_pkg
`timescale 1ns / 1ps
`default_nettype none

module msq_core (
  input  msq_pkg::msq_cfg_t                 cfg,
  input  msq_pkg::msq_state_t               state,
  input  logic [msq_pkg::TIME_WIDTH-1:0]    sample_time,
  input  logic                              raw_bit,
  output msq_pkg::msq_state_t               state_nxt,
  output logic                              event_fired
);
  import msq_pkg::*;

  logic                   active;
  logic                   started;
  logic [TIME_WIDTH-1:0]  since_start;
  logic [TIME_WIDTH-1:0]  since_fire;
  logic                   in_warmup;
  logic                   in_holdoff;
  logic                   prev_eff;
  logic                   count_max;

  assign active      = (raw_bit == cfg.active_polarity);
  assign started     = (sample_time >= cfg.start_time);
  assign since_start = sample_time - cfg.start_time;
  assign since_fire  = sample_time - state.last_fire_time;
  assign in_warmup   = CMP_WIDTH'(since_start) < CMP_WIDTH'(cfg.warmup_ms);
  assign in_holdoff  = (state.events_seen != '0) &&
                       (CMP_WIDTH'(since_fire) < CMP_WIDTH'(cfg.holdoff_ms));
  assign prev_eff    = state.seen_first ? state.prev_active : active;
  assign count_max   = &state.events_seen;

  always_comb begin
    state_nxt   = state;
    event_fired = 1'b0;
    if (started) begin
      state_nxt.seen_first  = 1'b1;
      state_nxt.prev_active = prev_eff;
      if (in_warmup) begin
        state_nxt.prev_active = active;
      end else if (!state.warmed_up) begin
        state_nxt.warmed_up   = 1'b1;
        state_nxt.prev_active = active;
      end else if (!active) begin
        state_nxt.prev_active = 1'b0;
      end else if (!prev_eff) begin
        state_nxt.prev_active = 1'b1;
        if (!in_holdoff) begin
          event_fired              = 1'b1;
          state_nxt.last_fire_time = sample_time;
          if (!count_max) begin
            state_nxt.events_seen = state.events_seen + COUNT_WIDTH'(1);
          end
        end
      end
    end
  end

endmodule

`default_nettype wire

/* hdl/motion_sensor_event_qualifier.sv */
// top level of the motion sensor event qualifier: ports, config registers, pipeline
// depends on msq_pkg and msq_core
`timescale 1ns / 1ps
`default_nettype none

// Qualifies timestamped one-bit motion detector samples into motion events. Every
// accepted item yields exactly one result item, via an input register that feeds the
// qualify logic and a result register; the qualifier state updates in the same cycle
// the result register loads. A new item can be accepted every clock while the result
// register is free; while a result waits on out_tready, the input register holds at
// most one more item and in_tready then drops. Configuration writes are always
// accepted and are meant to be issued only while no item is in flight.

module motion_sensor_event_qualifier (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // [47:0] sample_time, [48] raw_bit, [55:49] zero
  input  logic [msq_pkg::IN_DATA_WIDTH-1:0]     in_tdata,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // [0] event_fired, [1] is_stable, [49:2] event_time, [81:50] event_total, [87:82] zero
  output logic [msq_pkg::OUT_DATA_WIDTH-1:0]    out_tdata,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [msq_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
  input  logic [msq_pkg::CFG_DATA_WIDTH-1:0]    cfg_data
);
  import msq_pkg::*;

  localparam int OUT_PAD = OUT_DATA_WIDTH - 2 - TIME_WIDTH - COUNT_WIDTH;

  msq_cfg_t               cfg_r;
  msq_state_t             state_r;
  msq_state_t             state_nxt;
  logic                   in_v_r;
  logic [TIME_WIDTH-1:0]  time_r;
  logic                   raw_r;
  logic                   out_v_r;
  logic [OUT_DATA_WIDTH-1:0] out_data_r;
  logic                   fired;
  logic                   out_free;
  logic                   advance;

  assign cfg_ready  = 1'b1;
  assign out_free   = !out_v_r || out_tready;
  assign advance    = in_v_r && out_free;
  assign in_tready  = !in_v_r || out_free;
  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.active_polarity <= 1'b1;
      cfg_r.start_time      <= '0;
      cfg_r.warmup_ms       <= '0;
      cfg_r.holdoff_ms      <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ACTIVE_POLARITY: cfg_r.active_polarity <= cfg_data[0];
        REG_START_TIME:      cfg_r.start_time      <= cfg_data[TIME_WIDTH-1:0];
        REG_WARMUP_MS:       cfg_r.warmup_ms       <= cfg_data[MS_WIDTH-1:0];
        REG_HOLDOFF_MS:      cfg_r.holdoff_ms      <= cfg_data[MS_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_tready) begin
      in_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      time_r <= in_tdata[TIME_WIDTH-1:0];
      raw_r  <= in_tdata[TIME_WIDTH];
    end
  end

  msq_core u_core (
    .cfg         (cfg_r),
    .state       (state_r),
    .sample_time (time_r),
    .raw_bit     (raw_r),
    .state_nxt   (state_nxt),
    .event_fired (fired)
  );

  // qualifier state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (advance) begin
      state_r <= state_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_free) begin
      out_v_r <= in_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= {{OUT_PAD{1'b0}}, state_nxt.events_seen, state_nxt.last_fire_time,
                     state_nxt.warmed_up, fired};
    end
  end

endmodule

`default_nettype wire

/* tb/testbench.sv */
// self-checking bench for motion_sensor_event_qualifier: directed script, then random phases
// depends on msq_pkg and the qualifier rtl; expected results come from the script rows or an in-bench predictor
`timescale 1ns / 1ps

module testbench;
  import msq_pkg::*;

  typedef struct packed {
    logic                   fired;
    logic                   stable;
    logic [TIME_WIDTH-1:0]  ev_time;
    logic [COUNT_WIDTH-1:0] ev_total;
  } sensor_result_t;

  typedef enum logic {STEP_SAMPLE, STEP_WRITE} step_kind_t;

  typedef struct packed {
    step_kind_t                 kind;
    logic [CFG_INDEX_WIDTH-1:0] reg_index;
    logic [TIME_WIDTH-1:0]      value;
    logic                       raw;
    logic                       checked;
    sensor_result_t             want;
  } script_row_t;

  localparam logic [TIME_WIDTH-1:0] TIME_MAX = '1;
  localparam logic [MS_WIDTH-1:0]   MS_MAX   = '1;
  localparam int SCRIPT_LEN   = 28;
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 240;

  // sample rows carry the time in value
  localparam script_row_t SCRIPT [SCRIPT_LEN] = '{
    '{STEP_WRITE,  REG_WARMUP_MS, 48'd100, 1'b0, 1'b0, '{1'b0, 1'b0, 48'd0, 32'd0}},
    '{STEP_SAMPLE, '0, 48'd0,    1'b1, 1'b1, '{1'b0, 1'b0, 48'd0, 32'd0}},
    '{STEP_SAMPLE, '0, 48'd50,   1'b0, 1'b1, '{1'b0, 1'b0, 48'd0, 32'd0}},
    '{STEP_SAMPLE, '0, 48'd100,  1'b1, 1'b1, '{1'b0, 1'b1, 48'd0, 32'd0}},
    '{STEP_SAMPLE, '0, 48'd110,  1'b0, 1'b1, '{1'b0, 1'b1, 48'd0, 32'd0}},
    '{STEP_SAMPLE, '0, 48'd120,  1'b1, 1'b1, '{1'b1, 1'b1, 48'd120, 32'd1}},
    '{STEP_SAMPLE, '0, 48'd130,  1'b1, 1'b1, '{1'b0, 1'b1, 48'd120, 32'd1}},
    '{STEP_SAMPLE, '0, 48'd140,  1'b0, 1'b1, '{1'b0, 1'b1, 48'd120, 32'd1}},
    '{STEP_SAMPLE, '0, TIME_MAX, 1'b1, 1'b1, '{1'b1, 1'b1, TIME_MAX, 32'd2}},
    '{STEP_SAMPLE, '0, 48'd0,    1'b0, 1'b1, '{1'b0, 1'b1, TIME_MAX, 32'd2}},
    '{STEP_SAMPLE, '0, 48'd0,    1'b1, 1'b1, '{1'b0, 1'b1, TIME_MAX, 32'd2}},
    '{STEP_SAMPLE, '0, 48'd200,  1'b0, 1'b1, '{1'b0, 1'b1, TIME_MAX, 32'd2}},
    '{STEP_SAMPLE, '0, 48'd200,  1'b1, 1'b1, '{1'b1, 1'b1, 48'd200, 32'd3}},
    '{STEP_WRITE,  REG_ACTIVE_POLARITY, 48'd0, 1'b0, 1'b0, '{1'b0, 1'b0, 48'd0, 32'd0}},
    '{STEP_WRITE,  REG_START_TIME, 48'd1000, 1'b0, 1'b0, '{1'b0, 1'b0, 48'd0, 32'd0}},
    '{STEP_WRITE,  REG_WARMUP_MS, 48'd100, 1'b0, 1'b0, '{1'b0, 1'b0, 48'd0, 32'd0}},
    '{STEP_WRITE,  REG_HOLDOFF_MS, 48'd50, 1'b0, 1'b0, '{1'b0, 1'b0, 48'd0, 32'd0}},
    '{STEP_SAMPLE, '0, 48'd500,  1'b0, 1'b1, '{1'b0, 1'b1, 48'd200, 32'd3}},
    '{STEP_SAMPLE, '0, 48'd1050, 1'b1, 1'b1, '{1'b0, 1'b1, 48'd200, 32'd3}},
    '{STEP_SAMPLE, '0, 48'd1100, 1'b0, 1'b1, '{1'b1, 1'b1, 48'd1100, 32'd4}},
    '{STEP_SAMPLE, '0, 48'd1120, 1'b1, 1'b0, '{1'b0, 1'b0, 48'd0, 32'd0}},
    '{STEP_SAMPLE, '0, 48'd1130, 1'b0, 1'b0, '{1'b0, 1'b0, 48'd0, 32'd0}},
    '{STEP_SAMPLE, '0, 48'd1140, 1'b1, 1'b0, '{1'b0, 1'b0, 48'd0, 32'd0}},
    '{STEP_SAMPLE, '0, 48'd1150, 1'b0, 1'b1, '{1'b1, 1'b1, 48'd1150, 32'd5}},
    '{STEP_SAMPLE, '0, 48'd1200, 1'b1, 1'b1, '{1'b0, 1'b1, 48'd1150, 32'd5}},
    '{STEP_SAMPLE, '0, 48'd1149, 1'b0, 1'b1, '{1'b1, 1'b1, 48'd1149, 32'd6}},
    '{STEP_SAMPLE, '0, 48'd999,  1'b1, 1'b1, '{1'b0, 1'b1, 48'd1149, 32'd6}},
    '{STEP_SAMPLE, '0, TIME_MAX, 1'b0, 1'b0, '{1'b0, 1'b0, 48'd0, 32'd0}}
  };

  logic                       clk;
  logic                       rst_n;
  logic                       in_tvalid;
  logic                       in_tready;
  logic [IN_DATA_WIDTH-1:0]   in_tdata;
  logic                       out_tvalid;
  logic                       out_tready;
  logic [OUT_DATA_WIDTH-1:0]  out_tdata;
  logic                       cfg_valid;
  logic                       cfg_ready;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index;
  logic [CFG_DATA_WIDTH-1:0]  cfg_data;

  motion_sensor_event_qualifier dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // register shadows
  logic                  polarity_q;
  logic [TIME_WIDTH-1:0] start_q;
  logic [MS_WIDTH-1:0]   warmup_q;
  logic [MS_WIDTH-1:0]   holdoff_q;

  // predictor state
  logic                   seen_any;
  logic                   stable_now;
  logic                   was_active;
  logic [COUNT_WIDTH-1:0] fire_count;
  logic [TIME_WIDTH-1:0]  last_fire;

  sensor_result_t pending_results [$];
  int unsigned    faults;
  bit             quiet;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  initial begin
    #10ms;
    $display("testbench: FAIL");
    $finish;
  end

  function automatic logic [TIME_WIDTH-1:0] rand48();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[TIME_WIDTH-1:0];
  endfunction

  function automatic sensor_result_t qualify_sample(logic [TIME_WIDTH-1:0] now, logic raw);
    logic                  act;
    logic                  fired;
    logic [TIME_WIDTH-1:0] since_start;
    logic [TIME_WIDTH-1:0] since_fire;
    act = (raw == polarity_q);
    fired = 1'b0;
    since_start = now - start_q;
    since_fire = now - last_fire;
    if (now >= start_q) begin
      if (!seen_any) begin
        seen_any = 1'b1;
        was_active = act;
      end
      if (since_start < TIME_WIDTH'(warmup_q)) begin
        was_active = act;
      end else if (!stable_now) begin
        stable_now = 1'b1;
        was_active = act;
      end else if (!act) begin
        was_active = 1'b0;
      end else if (!was_active) begin
        was_active = 1'b1;
        if (!(fire_count != 0 && since_fire < TIME_WIDTH'(holdoff_q))) begin
          if (fire_count != '1) fire_count = fire_count + 1'b1;
          last_fire = now;
          fired = 1'b1;
        end
      end
    end
    return '{fired, stable_now, last_fire, fire_count};
  endfunction

  task automatic push_sample(logic [TIME_WIDTH-1:0] t, logic raw, logic checked,
                             sensor_result_t want);
    int gap;
    sensor_result_t predicted;
    gap = quiet ? 0 : $urandom_range(0, 14);
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {7'b0, raw, t};
    do @(posedge clk); while (!in_tready);
    predicted = qualify_sample(t, raw);
    pending_results.push_back(checked ? want : predicted);
  endtask

  task automatic cfg_write(logic [CFG_INDEX_WIDTH-1:0] idx, logic [CFG_DATA_WIDTH-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_ACTIVE_POLARITY: polarity_q = data[0];
      REG_START_TIME:      start_q = data[TIME_WIDTH-1:0];
      REG_WARMUP_MS:       warmup_q = data[MS_WIDTH-1:0];
      REG_HOLDOFF_MS:      holdoff_q = data[MS_WIDTH-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // stop offering and wait until every result is back
  task automatic settle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // result receiver with random stalls and two long hold-offs
  initial begin
    int gap;
    int taken;
    out_tready = 1'b0;
    taken = 0;
    wait (rst_n);
    forever begin
      gap = quiet ? 0 : $urandom_range(0, 14);
      if (taken == 600 || taken == 1500) gap = 300;
      @(negedge clk);
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      taken = taken + 1;
    end
  end

  always @(posedge clk) begin
    sensor_result_t want;
    sensor_result_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got = '{out_tdata[0], out_tdata[1], out_tdata[49:2], out_tdata[81:50]};
      if (pending_results.size() == 0) begin
        $error("result with nothing expected: %h", out_tdata);
        faults = faults + 1;
      end else begin
        want = pending_results.pop_front();
        if (got.fired !== want.fired) begin
          $error("event_fired: expected %0d, got %0d", want.fired, got.fired);
          faults = faults + 1;
        end
        if (got.stable !== want.stable) begin
          $error("is_stable: expected %0d, got %0d", want.stable, got.stable);
          faults = faults + 1;
        end
        if (got.ev_time !== want.ev_time) begin
          $error("event_time: expected %0d, got %0d", want.ev_time, got.ev_time);
          faults = faults + 1;
        end
        if (got.ev_total !== want.ev_total) begin
          $error("event_total: expected %0d, got %0d", want.ev_total, got.ev_total);
          faults = faults + 1;
        end
      end
    end
  end

  initial begin
    logic                  pol;
    logic [TIME_WIDTH-1:0] st;
    logic [MS_WIDTH-1:0]   wu;
    logic [MS_WIDTH-1:0]   ho;
    logic [TIME_WIDTH-1:0] junk;
    logic [TIME_WIDTH-1:0] stamp;
    logic [TIME_WIDTH-1:0] t;
    logic                  raw;
    int                    pick;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    faults = 0;
    quiet = 1'b0;
    polarity_q = 1'b1;
    start_q = '0;
    warmup_q = '0;
    holdoff_q = '0;
    seen_any = 1'b0;
    stable_now = 1'b0;
    was_active = 1'b0;
    fire_count = '0;
    last_fire = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (SCRIPT[k]) begin
      if (SCRIPT[k].kind == STEP_WRITE) begin
        settle();
        cfg_write(SCRIPT[k].reg_index, SCRIPT[k].value);
      end else begin
        push_sample(SCRIPT[k].value, SCRIPT[k].raw, SCRIPT[k].checked, SCRIPT[k].want);
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin pol = 1'b1; st = '0; wu = '0; ho = 32'd25; end
        1: begin pol = 1'b0; st = 48'd5000; wu = 32'd300; ho = '0; end
        2: begin pol = 1'b1; st = TIME_MAX; wu = '0; ho = MS_MAX; end
        3: begin pol = 1'b0; st = rand48(); wu = MS_MAX; ho = 32'd100; end
        default: begin
          pol = 1'($urandom_range(0, 1));
          st = rand48();
          wu = $urandom_range(0, 400);
          ho = $urandom_range(0, 200);
        end
      endcase
      settle();
      // junk in the bits above each register's width
      junk = rand48();
      cfg_write(REG_ACTIVE_POLARITY, {junk[TIME_WIDTH-1:1], pol});
      cfg_write(REG_START_TIME, st);
      junk = rand48();
      cfg_write(REG_WARMUP_MS, {junk[TIME_WIDTH-1:MS_WIDTH], wu});
      junk = rand48();
      cfg_write(REG_HOLDOFF_MS, {junk[TIME_WIDTH-1:MS_WIDTH], ho});
      stamp = st - TIME_WIDTH'($urandom_range(0, 50));
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (i % 50 == 0) quiet = ($urandom_range(0, 3) == 0);
        pick = $urandom_range(0, 99);
        raw = 1'($urandom_range(0, 1));
        if (pick < 80) begin
          stamp = stamp + TIME_WIDTH'($urandom_range(0, 40));
          t = stamp;
        end else if (pick < 90) begin
          t = st - TIME_WIDTH'($urandom_range(1, 100));
        end else if (pick < 95) begin
          t = stamp - TIME_WIDTH'($urandom_range(0, 200));
        end else begin
          t = rand48();
        end
        push_sample(t, raw, 1'b0, '0);
      end
    end

    settle();
    repeat (10) @(posedge clk);
    if (faults == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
